// File: rtl/srtm_pkg.sv
// ----------------------------------------------------------------------------
// srtm_pkg: shared types and constants for the symmetric rule table matcher
// Codes, token and write request types, and the symmetry variant decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package srtm_pkg;

	localparam int MAX_RULES_DEF  = 256;
	localparam int NUM_STATES_DEF = 16;
	localparam int NUM_POS        = 9;
	localparam int NUM_VAR        = 16;
	localparam int IDX_W          = 12;
	localparam int STATE_W        = 4;
	localparam int MASK_W         = 16;
	localparam int SLOT_W         = 4;

	// request kinds
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_EVAL  = 1'b1;

	// slot holding the next state
	localparam logic [SLOT_W-1:0] SLOT_NEXT = 4'd9;

	// symmetry modes
	localparam logic [2:0] SYM_NONE      = 3'd0;
	localparam logic [2:0] SYM_ROT4      = 3'd1;
	localparam logic [2:0] SYM_ROT8      = 3'd2;
	localparam logic [2:0] SYM_REFL      = 3'd3;
	localparam logic [2:0] SYM_ROT4_REFL = 3'd4;
	localparam logic [2:0] SYM_ROT8_REFL = 3'd5;

	// configuration register indexes
	localparam logic [1:0] CFG_SYMMETRY   = 2'd0;
	localparam logic [1:0] CFG_MOORE      = 2'd1;
	localparam logic [1:0] CFG_RULE_COUNT = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FIN
	} ctl_state_t;

	// one rule moving down the cell chain with its surviving variants
	typedef struct packed {
		logic               valid;
		logic [IDX_W-1:0]   idx;
		logic [NUM_VAR-1:0] vec;
	} tok_t;

	// rule word write broadcast to the cells
	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  addr;
		logic [SLOT_W-1:0] slot;
		logic [MASK_W-1:0] data;
	} rule_wr_t;

	// Variant j is rotation j/2, reflected when j is odd.
	function automatic logic [NUM_VAR-1:0] variant_enable(input logic [2:0] mode,
			input logic moore);
		logic [7:0]         rots;
		logic               refl;
		logic [NUM_VAR-1:0] en;
		rots = 8'b0000_0001;
		refl = 1'b0;
		en   = '0;
		unique case (mode)
			SYM_ROT4: begin
				rots = moore ? 8'b0101_0101 : 8'b0000_1111;
			end
			SYM_ROT8: begin
				rots = moore ? 8'b1111_1111 : 8'b0000_1111;
			end
			SYM_REFL: begin
				refl = 1'b1;
			end
			SYM_ROT4_REFL: begin
				rots = moore ? 8'b0101_0101 : 8'b0000_1111;
				refl = 1'b1;
			end
			SYM_ROT8_REFL: begin
				rots = moore ? 8'b1111_1111 : 8'b0000_1111;
				refl = 1'b1;
			end
			default: begin
				rots = 8'b0000_0001;
			end
		endcase
		for (int r = 0; r < 8; r++) begin
			en[2*r]   = rots[r];
			en[2*r+1] = rots[r] & refl;
		end
		return en;
	endfunction

endpackage

`default_nettype wire

// File: rtl/srtm_cell.sv
// ----------------------------------------------------------------------------
// srtm_cell: one neighbourhood position of the match chain
// Holds the mask column of its position and clears the variants whose state
// is not allowed, then hands the rule on to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module srtm_cell #(
	parameter int MAX_RULES  = 256,
	parameter int NUM_STATES = 16,
	parameter int POS        = 0
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  srtm_pkg::rule_wr_t   wr,
	input  wire                  used,
	input  wire [srtm_pkg::NUM_VAR-1:0][srtm_pkg::STATE_W-1:0] st,
	input  srtm_pkg::tok_t       tok_in,
	output srtm_pkg::tok_t       tok_out
);
	import srtm_pkg::*;

	localparam int RIDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;

	logic [MASK_W-1:0]  mask_mem_q [MAX_RULES];
	logic [MASK_W-1:0]  mask_s1;
	tok_t               tok_s1;
	tok_t               tok_s2;
	logic [NUM_VAR-1:0] allowed;

	// load the mask column
	always_ff @(posedge clk) begin
		if (wr.en && wr.slot == SLOT_W'(POS)) begin
			mask_mem_q[wr.addr[RIDX_W-1:0]] <= wr.data;
		end
	end

	// read the mask of the arriving rule
	always_ff @(posedge clk) begin
		mask_s1 <= mask_mem_q[tok_in.idx[RIDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
		end else begin
			tok_s1 <= tok_in;
		end
	end

	// test each variant's state against the mask
	always_comb begin
		for (int j = 0; j < NUM_VAR; j++) begin
			allowed[j] = !used ||
				(({3'b000, st[j]} < 7'(NUM_STATES)) && mask_s1[st[j]]);
		end
	end

	// advance to the neighbor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s2 <= '0;
		end else begin
			tok_s2.valid <= tok_s1.valid;
			tok_s2.idx   <= tok_s1.idx;
			tok_s2.vec   <= tok_s1.vec & allowed;
		end
	end

	assign tok_out = tok_s2;

endmodule

`default_nettype wire

// File: rtl/symmetric_rule_table_match.sv
// ----------------------------------------------------------------------------
// symmetric_rule_table_match: cellular automaton rule lookup with symmetry
// Scans the rule table in order through a chain of position cells and
// returns the next state of the first rule matching under any enabled variant.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries write requests (kind 0), which
//   store one mask word or next state, and evaluate requests (kind 1), which
//   give center and ring. Each evaluate request yields one result on the
//   output channel (out_valid/out_stall); write requests yield none.
//   Configuration is written on cfg_valid/cfg_ready while the block is idle.
// Timing:
//   A write request is stored when it is taken. An evaluate request is taken
//   only when the previous one has left the scan: rules enter the nine-cell
//   chain one per cycle and each cell registers the mask read and the rule,
//   then the rule with its pruned variants. A miss scans all rule_count rules;
//   a first match stops the issue, but the rules issued behind it drain
//   before the result is loaded. With zero rules the scan is skipped. The
//   input reopens in the cycle after the result is loaded.
//   The chain holds all sixteen symmetry variants side by side.
// Reset and stall:
//   Reset clears configuration to mode none, Moore, zero rules; the rule
//   table is not cleared. While the receiver stalls, the result holds in the
//   output register and a finished lookup waits before going idle.
// ----------------------------------------------------------------------------
`default_nettype none

module symmetric_rule_table_match #(
	parameter int MAX_RULES  = srtm_pkg::MAX_RULES_DEF,
	parameter int NUM_STATES = srtm_pkg::NUM_STATES_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire        kind,
	input  wire [7:0]  rule_index,
	input  wire [3:0]  rule_slot,
	input  wire [15:0] rule_value,
	input  wire [3:0]  center,
	input  wire [31:0] ring,
	output logic       out_valid,
	input  wire        out_stall,
	output logic [3:0] next_state,
	output logic       matched,
	output logic [7:0] matched_rule,
	input  wire        cfg_valid,
	output logic       cfg_ready,
	input  wire [1:0]  cfg_index,
	input  wire [15:0] cfg_data
);
	import srtm_pkg::*;

	localparam int RIDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
	localparam int CW_RAW = $clog2(MAX_RULES + 1);
	localparam int CNT_W  = (CW_RAW > 9) ? CW_RAW : 9;

	ctl_state_t st_q, st_d;

	logic [2:0]  sym_q;
	logic        moore_cfg_q;
	logic [8:0]  rule_count_q;

	logic [CNT_W-1:0] cnt_q, iss_q, ret_q, ret_nx;
	logic [NUM_VAR-1:0] en_q;
	logic [NUM_POS-1:0][NUM_VAR-1:0][STATE_W-1:0] var_q, var_d;
	logic [STATE_W-1:0] center_q;
	logic moore_q;
	logic found_q;
	logic [IDX_W-1:0] found_idx_q;
	logic [STATE_W-1:0] ns_mem_q [MAX_RULES];
	logic [STATE_W-1:0] ns_rd_q;

	logic out_valid_q, out_matched_q;
	logic [3:0] out_ns_q;
	logic [7:0] out_rule_q;

	tok_t chain [NUM_POS+1];
	rule_wr_t wr;
	logic acc, acc_eval, hit, out_load;
	logic [CNT_W-1:0] cnt_eff;

	assign cfg_ready = 1'b1;
	assign in_stall  = (st_q != ST_IDLE);
	assign acc       = in_valid && !in_stall;
	assign acc_eval  = acc && (kind == KIND_EVAL);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_q        <= SYM_NONE;
			moore_cfg_q  <= 1'b1;
			rule_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SYMMETRY:   sym_q        <= cfg_data[2:0];
				CFG_MOORE:      moore_cfg_q  <= cfg_data[0];
				CFG_RULE_COUNT: rule_count_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// broadcast rule writes
	always_comb begin
		wr.en   = acc && (kind == KIND_WRITE) && (32'(rule_index) < MAX_RULES);
		wr.addr = IDX_W'(rule_index);
		wr.slot = rule_slot;
		wr.data = rule_value;
	end

	always_ff @(posedge clk) begin
		if (wr.en && wr.slot == SLOT_NEXT) begin
			ns_mem_q[wr.addr[RIDX_W-1:0]] <= wr.data[STATE_W-1:0];
		end
	end

	assign cnt_eff = (32'(rule_count_q) > MAX_RULES) ? CNT_W'(MAX_RULES)
	                                                   : CNT_W'(rule_count_q);

	// state seen at each position under each variant
	always_comb begin
		logic [2:0] rot, mir, sel, src;
		logic       refl;
		var_d = '0;
		for (int j = 0; j < NUM_VAR; j++) begin
			rot  = 3'(j >> 1);
			refl = j[0];
			var_d[0][j] = center;
			for (int i = 0; i < 8; i++) begin
				mir = moore_cfg_q ? 3'(8 - i) : {1'b0, 2'(4 - i)};
				sel = refl ? mir : 3'(i);
				src = moore_cfg_q ? 3'(sel + rot) : {1'b0, 2'(sel + rot)};
				var_d[i+1][j] = ring[int'(src)*4 +: 4];
			end
		end
	end

	// hold the request for the scan
	always_ff @(posedge clk) begin
		if (acc_eval) begin
			var_q    <= var_d;
			center_q <= center;
			en_q     <= variant_enable(sym_q, moore_cfg_q);
			moore_q  <= moore_cfg_q;
			cnt_q    <= cnt_eff;
		end
	end

	// issue one rule a cycle into the chain
	always_comb begin
		chain[0].valid = (st_q == ST_SCAN);
		chain[0].idx   = IDX_W'(iss_q);
		chain[0].vec   = en_q;
	end

	for (genvar p = 0; p < NUM_POS; p++) begin : g_cell
		srtm_cell #(
			.MAX_RULES  (MAX_RULES),
			.NUM_STATES (NUM_STATES),
			.POS        (p)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.wr      (wr),
			.used    ((p <= 4) || moore_q),
			.st      (var_q[p]),
			.tok_in  (chain[p]),
			.tok_out (chain[p+1])
		);
	end

	assign hit    = chain[NUM_POS].valid && (|chain[NUM_POS].vec) && !found_q;
	assign ret_nx = chain[NUM_POS].valid ? CNT_W'(ret_q + 1'b1) : ret_q;

	always_ff @(posedge clk) begin
		if (hit) begin
			ns_rd_q     <= ns_mem_q[chain[NUM_POS].idx[RIDX_W-1:0]];
			found_idx_q <= chain[NUM_POS].idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			iss_q   <= '0;
			ret_q   <= '0;
			found_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (acc_eval) begin
				iss_q   <= '0;
				ret_q   <= '0;
				found_q <= 1'b0;
			end else begin
				if (chain[0].valid) iss_q <= CNT_W'(iss_q + 1'b1);
				ret_q <= ret_nx;
				if (hit) found_q <= 1'b1;
			end
		end
	end

	// sequencer
	always_comb begin
		st_d     = st_q;
		out_load = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				if (acc_eval) st_d = (cnt_eff == '0) ? ST_FIN : ST_SCAN;
			end
			ST_SCAN: begin
				if (hit || CNT_W'(iss_q + 1'b1) == cnt_q) st_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (ret_nx == iss_q) st_d = ST_FIN;
			end
			ST_FIN: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					st_d     = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_ns_q      <= found_q ? ns_rd_q : center_q;
			out_matched_q <= found_q;
			out_rule_q    <= found_q ? found_idx_q[7:0] : 8'd0;
		end
	end

	assign out_valid    = out_valid_q;
	assign next_state   = out_ns_q;
	assign matched      = out_matched_q;
	assign matched_rule = out_rule_q;

	a_ret_le_iss: assert property (@(posedge clk) disable iff (!arst_n)
		ret_q <= iss_q) else $error("more rules retired than issued");
	a_iss_le_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_SCAN || st_q == ST_DRAIN) |-> iss_q <= cnt_q)
		else $error("issued beyond rule count");
	a_found_idx: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(found_q) |-> 32'(found_idx_q) < 32'(cnt_q))
		else $error("match outside scanned rules");
	a_load_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(st_q == ST_FIN))
		else $error("result loaded outside finish");
	a_drain_empty: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_FIN |-> ret_q == iss_q)
		else $error("finish with rules in flight");

endmodule

`default_nettype wire

// File: tb/symmetric_rule_table_match_tb.sv
// ----------------------------------------------------------------------------
// symmetric_rule_table_match_tb: self-checking bench for the rule matcher
// Loads the low part of the rule table with a catch-all rule at its top,
// then walks through symmetry modes, both neighbourhoods and many rule
// counts, checking each lookup result against a behavioral first-match
// scan, with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module symmetric_rule_table_match_tb;
	import srtm_pkg::*;

	localparam int TABLE_DEPTH = 256;
	localparam int LOAD_RULES  = 64;
	localparam int CATCH_RULE  = 63;
	localparam int SETTLE_CYC  = 300;
	localparam int HOLD_CYC    = 400;
	localparam int WDOG_LIMIT  = 5000;

	typedef struct {
		logic        kind;
		logic [7:0]  idx;
		logic [3:0]  slot;
		logic [15:0] value;
		logic [3:0]  center;
		logic [31:0] ring;
	} request_t;

	typedef struct {
		logic [3:0] next_state;
		logic       matched;
		logic [7:0] matched_rule;
	} lookup_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        kind = 1'b0;
	logic [7:0]  rule_index = '0;
	logic [3:0]  rule_slot = '0;
	logic [15:0] rule_value = '0;
	logic [3:0]  center = '0;
	logic [31:0] ring = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [3:0]  next_state;
	logic        matched;
	logic [7:0]  matched_rule;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	symmetric_rule_table_match u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .rule_index(rule_index), .rule_slot(rule_slot),
		.rule_value(rule_value), .center(center), .ring(ring),
		.out_valid(out_valid), .out_stall(out_stall),
		.next_state(next_state), .matched(matched), .matched_rule(matched_rule),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// shadow of the rule table and configuration
	logic [15:0] mask_tbl [TABLE_DEPTH][NUM_POS];
	logic [3:0]  next_tbl [TABLE_DEPTH];
	logic [2:0]  sym_mode = SYM_NONE;
	logic        moore_on = 1'b1;
	logic [8:0]  rule_cnt = '0;

	request_t pending_q[$];
	lookup_t  lookup_q[$];
	request_t cur_req;

	int  tx_gap = 0, rx_gap = 0, hold_cnt = 0;
	int  hold_id = 0, hold_seen = 0;
	bit  idle_on = 1'b1;
	int  errors = 0, n_evals = 0, n_writes = 0, n_hits = 0, n_phases = 0;
	int  quiet_cyc = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// append one request to the pending queue
	function automatic void add_pending(request_t q);
		pending_q = {pending_q, q};
	endfunction

	// gap length: mostly none or short, a few long
	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 60) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic bit pos_ok(int r, int p, logic [3:0] s);
		return mask_tbl[r][p][s];
	endfunction

	// first-match scan over all allowed rotations and reflections
	function automatic lookup_t scan_rules(logic [3:0] c, logic [31:0] rg);
		lookup_t    res;
		logic [3:0] v[9], rv[9], fv[9];
		int nring, nrot, skip, lim, rot;
		bit refl, hit;
		nring = moore_on ? 8 : 4;
		v[0] = c;
		for (int i = 0; i < 8; i++) v[1+i] = rg[4*i +: 4];
		nrot = 1; skip = 1; refl = 1'b0;
		case (sym_mode)
			SYM_ROT4:      begin nrot = 4; skip = moore_on ? 2 : 1; end
			SYM_ROT8:      begin nrot = 8; end
			SYM_REFL:      begin refl = 1'b1; end
			SYM_ROT4_REFL: begin nrot = 4; skip = moore_on ? 2 : 1; refl = 1'b1; end
			SYM_ROT8_REFL: begin nrot = 8; refl = 1'b1; end
			default:       begin nrot = 1; end
		endcase
		lim = (rule_cnt > TABLE_DEPTH) ? TABLE_DEPTH : rule_cnt;
		res.next_state = c;
		res.matched = 1'b0;
		res.matched_rule = '0;
		for (int r = 0; r < lim; r++) begin
			for (int k = 0; k < nrot; k++) begin
				rot = (k * skip) % nring;
				rv[0] = v[0];
				for (int i = 0; i < nring; i++) rv[1+i] = v[1 + (i + rot) % nring];
				hit = 1'b1;
				for (int p = 0; p <= nring; p++) hit &= pos_ok(r, p, rv[p]);
				if (!hit && refl) begin
					fv = rv;
					if (moore_on) begin
						fv[2] = rv[8]; fv[8] = rv[2];
						fv[3] = rv[7]; fv[7] = rv[3];
						fv[4] = rv[6]; fv[6] = rv[4];
					end else begin
						fv[2] = rv[4]; fv[4] = rv[2];
					end
					hit = 1'b1;
					for (int p = 0; p <= nring; p++) hit &= pos_ok(r, p, fv[p]);
				end
				if (hit) begin
					res.next_state = next_tbl[r];
					res.matched = 1'b1;
					res.matched_rule = r[7:0];
					return res;
				end
			end
		end
		return res;
	endfunction

	// apply one accepted request to the shadow state
	function automatic void absorb_request(request_t q);
		if (q.kind == KIND_WRITE) begin
			n_writes++;
			if (q.slot < NUM_POS) mask_tbl[q.idx][q.slot] = q.value;
			else if (q.slot == SLOT_NEXT) next_tbl[q.idx] = q.value[3:0];
		end else begin
			n_evals++;
			lookup_q = {lookup_q, scan_rules(q.center, q.ring)};
		end
	endfunction

	// sender: present requests from the pending queue with random gaps
	always @(posedge clk or negedge arst_n) begin
		bit go, nv;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			go = in_valid && !in_stall;
			if (go) absorb_request(cur_req);
			if (!in_valid || go) begin
				nv = 1'b0;
				if (tx_gap > 0) begin
					tx_gap--;
				end else if (pending_q.size() > 0) begin
					cur_req = pending_q.pop_front();
					kind <= cur_req.kind;
					rule_index <= cur_req.idx;
					rule_slot <= cur_req.slot;
					rule_value <= cur_req.value;
					center <= cur_req.center;
					ring <= cur_req.ring;
					nv = 1'b1;
					tx_gap = idle_on ? pick_gap() : 0;
				end
				in_valid <= nv;
			end
		end
	end

	// receiver: check results, stall at random or for a long hold
	always @(posedge clk or negedge arst_n) begin
		lookup_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (lookup_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("ERROR: unexpected result ns=%0d m=%0d r=%0d",
							next_state, matched, matched_rule);
				end else begin
					e = lookup_q.pop_front();
					if (e.matched) n_hits++;
					if (next_state !== e.next_state || matched !== e.matched ||
							matched_rule !== e.matched_rule) begin
						errors++;
						if (errors <= 10)
							$display("ERROR: lookup exp ns=%0d m=%0d r=%0d got ns=%0d m=%0d r=%0d",
								e.next_state, e.matched, e.matched_rule,
								next_state, matched, matched_rule);
					end
				end
			end
			if (hold_id != hold_seen) begin
				hold_seen = hold_id;
				hold_cnt = HOLD_CYC;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_stall <= 1'b1;
			end else if (rx_gap > 0) begin
				rx_gap--;
				out_stall <= 1'b1;
			end else begin
				rx_gap = idle_on ? pick_gap() : 0;
				out_stall <= 1'b0;
			end
		end
	end

	// watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cyc <= 0;
		else
			quiet_cyc <= quiet_cyc + 1;
		if (quiet_cyc >= WDOG_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", WDOG_LIMIT);
			$display("symmetric_rule_table_match_tb: done, errors");
			$finish;
		end
	end

	function automatic request_t wr_req(int r, int s, logic [15:0] val);
		request_t q;
		q = '{KIND_WRITE, r[7:0], s[3:0], val, 4'($urandom), $urandom};
		return q;
	endfunction

	function automatic request_t ev_req(logic [3:0] c, logic [31:0] rg);
		request_t q;
		q = '{KIND_EVAL, 8'($urandom), 4'($urandom), 16'($urandom), c, rg};
		return q;
	endfunction

	// mask biased toward states 0..3 so matches happen at varied rules
	function automatic logic [15:0] rand_mask();
		int p;
		p = $urandom_range(0, 9);
		if (p == 0) return 16'hFFFF;
		if (p == 1) return 16'($urandom);
		return {12'($urandom), 4'($urandom | $urandom)};
	endfunction

	function automatic logic [3:0] rand_state();
		return ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
	endfunction

	task automatic wait_drained();
		while (pending_q.size() != 0 || in_valid || lookup_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_cfg(logic [1:0] idx, logic [15:0] val);
		wait_drained();
		repeat (SETTLE_CYC) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_SYMMETRY:   sym_mode = val[2:0];
			CFG_MOORE:      moore_on = val[0];
			CFG_RULE_COUNT: rule_cnt = val[8:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	task automatic set_phase(logic [2:0] s, logic m, int cnt);
		write_cfg(CFG_SYMMETRY, {13'($urandom), s});
		write_cfg(CFG_MOORE, {15'($urandom), m});
		write_cfg(CFG_RULE_COUNT, 16'(cnt));
		n_phases++;
	endtask

	// random requests: mostly lookups, some table rewrites
	task automatic push_random(int n, int max_rule);
		logic [31:0] rg;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 15) begin
				add_pending(wr_req($urandom_range(0, max_rule),
					$urandom_range(0, 15), rand_mask()));
			end else begin
				rg = $urandom;
				for (int j = 0; j < 8; j++) rg[4*j +: 4] = rand_state();
				if ($urandom_range(0, 9) == 0) rg = $urandom;
				add_pending(ev_req(rand_state(), rg));
			end
		end
	endtask

	initial begin
		int cnt;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// load the low rules, the top one allowing every state, plus zero-rule lookups
		for (int r = 0; r < LOAD_RULES; r++)
			for (int s = 0; s <= SLOT_NEXT; s++)
				add_pending(wr_req(r, s,
					(r == CATCH_RULE && s < NUM_POS) ? 16'hFFFF : rand_mask()));
		add_pending(ev_req(4'h0, 32'h0));
		add_pending(ev_req(4'hF, 32'hFFFF_FFFF));
		wait_drained();

		// directed: extremes, unused slots, next-state truncation, top entry
		set_phase(SYM_NONE, 1'b1, 2);
		for (int s = 0; s < NUM_POS; s++) add_pending(wr_req(0, s, 16'h8001));
		add_pending(wr_req(0, SLOT_NEXT, 16'hFFF5));
		add_pending(wr_req(0, 15, 16'h0000));
		add_pending(wr_req(0, 10, 16'h0000));
		add_pending(ev_req(4'h0, 32'h0));
		add_pending(ev_req(4'hF, 32'hFFFF_FFFF));
		add_pending(ev_req(4'h0, 32'hF0F0_F0F0));
		add_pending(ev_req(4'h7, 32'h7777_7777));
		add_pending(wr_req(255, SLOT_NEXT, 16'h000A));
		add_pending(wr_req(255, 0, 16'hFFFF));
		wait_drained();

		// long scan: count at table size and beyond, stopped by the catch-all rule
		for (int s = 0; s < NUM_POS; s++) add_pending(wr_req(0, s, rand_mask()));
		set_phase(SYM_ROT8_REFL, 1'b1, 256);
		push_random(20, CATCH_RULE - 1);
		set_phase(SYM_ROT4, 1'b0, 511);
		push_random(20, CATCH_RULE - 1);

		// receiver holds off while the sender keeps offering lookups
		set_phase(SYM_ROT8, 1'b1, 8);
		idle_on = 1'b0;
		hold_id <= hold_id + 1;
		push_random(40, 15);
		wait_drained();
		idle_on = 1'b1;

		// sweep every mode on both neighbourhoods with small rule counts
		for (int pass = 0; pass < 2; pass++) begin
			for (int s = 0; s < 8; s++) begin
				for (int m = 0; m < 2; m++) begin
					cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 64)
						: $urandom_range(1, 16);
					set_phase(s[2:0], m[0], cnt);
					idle_on = ($urandom_range(0, 3) != 0);
					push_random(12, 31);
				end
			end
		end
		idle_on = 1'b1;

		wait_drained();
		repeat (SETTLE_CYC) @(posedge clk);
		$display("run: %0d lookups (%0d matched), %0d table writes, %0d config phases",
			n_evals, n_hits, n_writes, n_phases);
		$display("     all symmetry modes, both neighbourhoods, rule counts 0..511, long hold");
		if (errors == 0 && lookup_q.size() == 0) begin
			$display("symmetric_rule_table_match_tb: done, clean");
		end else begin
			$display("mismatches: %0d, results missing: %0d", errors, lookup_q.size());
			$display("symmetric_rule_table_match_tb: done, errors");
		end
		$finish;
	end

endmodule
